### sv/bitplane_framebuffer_defines.svh
// Assertion macros shared by the framebuffer RTL.
`ifndef BITPLANE_FRAMEBUFFER_DEFINES_SVH
`define BITPLANE_FRAMEBUFFER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/bfb_pkg.sv
// Shared types, codes and default sizes of the bit-plane framebuffer.
package bfb_pkg;

  // Default geometry
  localparam int NUM_BUFFERS_DEF  = 2;
  localparam int FRAME_WIDTH_DEF  = 64;
  localparam int FRAME_HEIGHT_DEF = 32;
  localparam int PLANES_DEF       = 3;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Action codes
  localparam logic [2:0] ACT_PLOT  = 3'd0;
  localparam logic [2:0] ACT_GET   = 3'd1;
  localparam logic [2:0] ACT_FILL  = 3'd2;
  localparam logic [2:0] ACT_SWAP  = 3'd3;
  localparam logic [2:0] ACT_RREAD = 3'd4;

  typedef struct packed {
    logic [2:0] action;
    logic       use_active;
    logic       buffer_sel;
    logic [5:0] x_pos;
    logic [4:0] y_pos;
    logic [2:0] color;
  } in_item_t;

  typedef struct packed {
    logic [2:0] pixel;
    logic       active_now;
    logic       render_now;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [2:0] action;
    logic       use_active;
    logic       buffer_sel;
    logic       sel_ok;
    logic       pos_ok;
    logic [5:0] x_pos;
    logic [4:0] y_pos;
    logic [2:0] color;
  } bfb_cmd_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } bfb_status_t;

endpackage

### sv/bfb_ram.sv
// Generic single-port RAM with registered read data.
module bfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

### sv/bfb_front.sv
// Front end: classifies an incoming item into a command for the back end.
module bfb_front #(
  parameter int NUM_BUFFERS  = bfb_pkg::NUM_BUFFERS_DEF,
  parameter int FRAME_WIDTH  = bfb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bfb_pkg::FRAME_HEIGHT_DEF
) (
  input  bfb_pkg::in_item_t item,
  output bfb_pkg::bfb_cmd_t cmd
);

  // Check explicit buffer and coordinates against the frame geometry
  always_comb begin
    cmd.action     = item.action;
    cmd.use_active = item.use_active;
    cmd.buffer_sel = item.buffer_sel;
    cmd.sel_ok     = (32'(item.buffer_sel) < NUM_BUFFERS);
    cmd.pos_ok     = (32'(item.x_pos) < FRAME_WIDTH) && (32'(item.y_pos) < FRAME_HEIGHT);
    cmd.x_pos      = item.x_pos;
    cmd.y_pos      = item.y_pos;
    cmd.color      = item.color;
  end

endmodule

### sv/bfb_queue.sv
// Short command queue that decouples the front end from the back end.
module bfb_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bfb_pkg::bfb_cmd_t push_cmd,
  input  logic              pop,
  output logic              valid,
  output logic              full,
  output bfb_pkg::bfb_cmd_t head
);

  localparam int PW = (bfb_pkg::QUEUE_DEPTH > 1) ? $clog2(bfb_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(bfb_pkg::QUEUE_DEPTH + 1);

  bfb_pkg::bfb_cmd_t entry_r [bfb_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign valid = (count_r != '0);
  assign full  = (count_r == CW'(bfb_pkg::QUEUE_DEPTH));
  assign head  = entry_r[rd_ptr_r];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == bfb_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == bfb_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### sv/bfb_back.sv
// Back end: executes commands against the pixel store and issues results.
module bfb_back #(
  parameter int NUM_BUFFERS  = bfb_pkg::NUM_BUFFERS_DEF,
  parameter int FRAME_WIDTH  = bfb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bfb_pkg::FRAME_HEIGHT_DEF,
  parameter int PLANES       = bfb_pkg::PLANES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  bfb_pkg::bfb_cmd_t  cmd,
  output logic               cmd_pop,
  output logic               clearing,
  output logic               out_valid,
  output bfb_pkg::out_item_t out_data
);

  localparam int PIX   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int TOTAL = NUM_BUFFERS * PIX;
  localparam int AW    = $clog2(TOTAL);
  localparam int BW    = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  function automatic logic [AW-1:0] base_of(input logic [BW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(b) * (AW+1)'(PIX);
    return s[AW-1:0];
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [BW-1:0]      active_r, active_nxt;
  logic [BW-1:0]      render_r, render_nxt;
  logic [AW-1:0]      sweep_addr_r, sweep_addr_nxt;
  logic [AW-1:0]      sweep_last_r, sweep_last_nxt;
  logic [PLANES-1:0]  sweep_color_r, sweep_color_nxt;
  logic               sweep_report_r, sweep_report_nxt;
  logic               rd_hit_r, rd_hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  bfb_pkg::out_item_t out_data_r, out_data_nxt;

  logic [BW-1:0]     buf_sel;
  logic [BW-1:0]     acc_buf;
  logic              buf_ok;
  logic [BW:0]       active_inc;
  logic [BW-1:0]     active_wrap;
  logic [AW:0]       offset;
  logic [AW-1:0]     cmd_addr;
  logic [7:0]        color_ext;
  logic [PLANES-1:0] color_p;
  logic [7:0]        rd_ext;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [PLANES-1:0] ram_wdata;
  logic [PLANES-1:0] ram_rdata;

  bfb_ram #(
    .WIDTH (PLANES),
    .DEPTH (TOTAL)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Resolve the buffer and the pixel address of the head command
  always_comb begin
    buf_sel     = cmd.use_active ? active_r : BW'(cmd.buffer_sel);
    buf_ok      = cmd.use_active || cmd.sel_ok;
    acc_buf     = (cmd.action == bfb_pkg::ACT_RREAD) ? render_r : buf_sel;
    offset      = (AW+1)'(cmd.y_pos) * (AW+1)'(FRAME_WIDTH) + (AW+1)'(cmd.x_pos);
    cmd_addr    = base_of(acc_buf) + offset[AW-1:0];
    active_inc  = {1'b0, active_r} + 1'b1;
    active_wrap = (32'(active_inc) >= NUM_BUFFERS) ? '0 : active_inc[BW-1:0];
    color_ext   = 8'(cmd.color);
    color_p     = color_ext[PLANES-1:0];
    rd_ext      = 8'(ram_rdata);
  end

  // Sequence plot, reads and buffer sweeps
  always_comb begin
    state_nxt        = state_r;
    active_nxt       = active_r;
    render_nxt       = render_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_last_nxt   = sweep_last_r;
    sweep_color_nxt  = sweep_color_r;
    sweep_report_nxt = sweep_report_r;
    rd_hit_nxt       = rd_hit_r;
    out_valid_nxt    = 1'b0;
    out_data_nxt     = out_data_r;
    cmd_pop          = 1'b0;
    ram_we           = 1'b0;
    ram_addr         = cmd_addr;
    ram_wdata        = color_p;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.action)
            bfb_pkg::ACT_PLOT: begin
              ram_we        = buf_ok && cmd.pos_ok;
              out_valid_nxt = 1'b1;
            end
            bfb_pkg::ACT_GET: begin
              rd_hit_nxt = buf_ok && cmd.pos_ok;
              state_nxt  = ST_READ;
            end
            bfb_pkg::ACT_RREAD: begin
              rd_hit_nxt = cmd.pos_ok;
              state_nxt  = ST_READ;
            end
            bfb_pkg::ACT_FILL: begin
              sweep_addr_nxt   = base_of(active_r);
              sweep_last_nxt   = base_of(active_r) + AW'(PIX - 1);
              sweep_color_nxt  = color_p;
              sweep_report_nxt = 1'b1;
              state_nxt        = ST_SWEEP;
            end
            bfb_pkg::ACT_SWAP: begin
              render_nxt       = active_r;
              active_nxt       = active_wrap;
              sweep_addr_nxt   = base_of(active_wrap);
              sweep_last_nxt   = base_of(active_wrap) + AW'(PIX - 1);
              sweep_color_nxt  = '0;
              sweep_report_nxt = 1'b1;
              state_nxt        = ST_SWEEP;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
          out_data_nxt.pixel = '0;
        end
      end
      ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_data_nxt.pixel = rd_hit_r ? rd_ext[2:0] : 3'd0;
        state_nxt          = ST_IDLE;
      end
      ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_addr_r;
        ram_wdata = sweep_color_r;
        if (sweep_addr_r == sweep_last_r) begin
          out_valid_nxt      = sweep_report_r;
          out_data_nxt.pixel = '0;
          state_nxt          = ST_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_data_nxt.active_now = active_nxt[0];
    out_data_nxt.render_now = render_nxt[0];
  end

  // Control state; reset starts the clearing pass over the whole store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_SWEEP;
      active_r       <= '0;
      render_r       <= '0;
      sweep_addr_r   <= '0;
      sweep_last_r   <= AW'(TOTAL - 1);
      sweep_color_r  <= '0;
      sweep_report_r <= 1'b0;
      rd_hit_r       <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      active_r       <= active_nxt;
      render_r       <= render_nxt;
      sweep_addr_r   <= sweep_addr_nxt;
      sweep_last_r   <= sweep_last_nxt;
      sweep_color_r  <= sweep_color_nxt;
      sweep_report_r <= sweep_report_nxt;
      rd_hit_r       <= rd_hit_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign clearing  = (state_r == ST_SWEEP) && !sweep_report_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/bitplane_framebuffer.sv
// Top level of the multi-buffered bit-plane framebuffer.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------
//   input    | start / busy        | in_data  (in_item_t)
//   result   | out_valid (strobe)  | out_data (out_item_t)
//
// An accepted item reaches the back end through a two-entry command queue.
// Plot and unused actions complete in the idle state; get and render read
// also pass the read state for the registered RAM read. Fill and swap write
// one pixel per cycle over a whole buffer, limited by the single RAM port.
// After reset a clearing pass zeroes the store; busy stays high throughout.
// busy is high while the queue is full; results appear as one-cycle strobes.
`include "bitplane_framebuffer_defines.svh"

module bitplane_framebuffer #(
  parameter int NUM_BUFFERS  = bfb_pkg::NUM_BUFFERS_DEF,
  parameter int FRAME_WIDTH  = bfb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = bfb_pkg::FRAME_HEIGHT_DEF,
  parameter int PLANES       = bfb_pkg::PLANES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bfb_pkg::in_item_t  in_data,
  output logic               out_valid,
  output bfb_pkg::out_item_t out_data
);

  bfb_pkg::bfb_cmd_t    front_cmd;
  bfb_pkg::bfb_cmd_t    q_head;
  bfb_pkg::bfb_status_t status;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_valid;
  logic                 q_full;
  logic                 clearing;

  bfb_front #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  bfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  bfb_back #(
    .NUM_BUFFERS  (NUM_BUFFERS),
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .PLANES       (PLANES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (q_head),
    .cmd_pop   (q_pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Stall intake while the queue is full or the store is being cleared
  always_comb begin
    status.clearing = clearing;
    status.busy     = q_full || clearing;
  end

  assign busy   = status.busy;
  assign q_push = start && !status.busy;

  `BFB_ASSERT_NOW(a_no_result_in_clear, status.clearing, !out_valid, "result during clear pass")
  `BFB_ASSERT_NEXT(a_clear_once, !status.clearing, !status.clearing, "clear pass restarted")
  `BFB_ASSERT_NOW(a_pop_nonempty, q_pop, q_valid, "pop from empty command queue")

endmodule
